>>> hw/rtl/aire_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aire_pkg: shared definitions for the array insert/remove engine
// Field widths, action and status codes, and the controller command type.
// ----------------------------------------------------------------------------
package aire_pkg;

	// Fixed field widths.
	localparam int ACT_W   = 2;
	localparam int POS_W   = 4;
	localparam int VAL_W   = 32;
	localparam int STAT_W  = 2;
	localparam int ECNT_W  = 5;

	// Default number of entries.
	localparam int DEPTH_DEF = 16;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;   // capture an accepted item
		logic exec;   // apply the captured item and load the result register
	} aire_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/aire_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aire_req_if: request channel
// Carries one operation item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface aire_req_if;
	import aire_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ACT_W-1:0]        action;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] new_value;

	modport source (output valid, output action, output position, output new_value,
		input ready);
	modport sink (input valid, input action, input position, input new_value,
		output ready);
endinterface

`default_nettype wire

>>> hw/rtl/aire_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aire_rsp_if: response channel
// Carries one result item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface aire_rsp_if;
	import aire_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic [ECNT_W-1:0]       entry_count;
	logic signed [VAL_W-1:0] read_value;

	modport source (output valid, output status, output entry_count, output read_value,
		input ready);
	modport sink (input valid, input status, input entry_count, input read_value,
		output ready);
endinterface

`default_nettype wire

>>> hw/rtl/aire_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aire_ctrl: sequencing controller
// Accepts one item, executes it once the result register is free, and
// tracks the valid flag of the result register.
// ----------------------------------------------------------------------------
module aire_ctrl
	import aire_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output aire_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_vld_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;
	assign out_free  = !out_vld_q || out_ready;

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/aire_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aire_dpath: entry array datapath
// Holds the captured item, the row of entry cells that shift in parallel,
// the entry count and the result register.
// ----------------------------------------------------------------------------
module aire_dpath
	import aire_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire aire_cmd_t               cmd,
	input  wire logic [ACT_W-1:0]        in_action,
	input  wire logic [POS_W-1:0]        in_position,
	input  wire logic signed [VAL_W-1:0] in_new_value,
	output logic [STAT_W-1:0]            out_status,
	output logic [ECNT_W-1:0]            out_entry_count,
	output logic signed [VAL_W-1:0]      out_read_value
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Captured item.
	logic [ACT_W-1:0]        act_q;
	logic [POS_W-1:0]        pos_q;
	logic [VAL_W-1:0]        val_q;

	logic [VAL_W-1:0]        ent_q [DEPTH];
	logic [CNT_W-1:0]        cnt_q;

	logic [CMP_W-1:0]        pos_ext;
	logic [CMP_W-1:0]        cnt_cmp;
	logic [CNT_W+ECNT_W-1:0] cnt_wide;
	logic                    do_ins;
	logic                    do_rem;
	logic [STAT_W-1:0]       stat_d;
	logic [VAL_W-1:0]        rd_d;
	logic [CNT_W-1:0]        cnt_d;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			pos_q <= in_position;
			val_q <= in_new_value;
		end
	end

	assign pos_ext = CMP_W'(pos_q);
	assign cnt_cmp = CMP_W'(cnt_q);

	// Decode the operation and check the position against the count.
	always_comb begin
		do_ins = 1'b0;
		do_rem = 1'b0;
		stat_d = ST_DONE;
		rd_d   = '0;
		cnt_d  = cnt_q;
		unique case (act_q)
			ACT_INSERT: begin
				if (pos_ext > cnt_cmp) begin
					stat_d = ST_RANGE;
				end else if (cnt_cmp == CMP_W'(DEPTH)) begin
					stat_d = ST_FULL;
				end else begin
					do_ins = 1'b1;
					cnt_d  = cnt_q + 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (pos_ext >= cnt_cmp) begin
					stat_d = ST_RANGE;
				end else begin
					do_rem = 1'b1;
					cnt_d  = cnt_q - 1'b1;
				end
			end
			ACT_READ: begin
				if (pos_ext >= cnt_cmp) begin
					stat_d = ST_RANGE;
				end else begin
					rd_d = ent_q[pos_ext[IDX_W-1:0]];
				end
			end
			default: begin
				// Unused action code: no change, done status.
			end
		endcase
	end

	// Entry cells: each takes its lower or upper neighbor, or the new value.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic above;
		logic at;
		assign above = (CMP_W'(i) > pos_ext);
		assign at    = (CMP_W'(i) == pos_ext);

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (do_ins && at) begin
					ent_q[i] <= val_q;
				end
				if (i > 0) begin
					if (do_ins && above) begin
						ent_q[i] <= ent_q[(i > 0) ? i - 1 : 0];
					end
				end
				if (i < DEPTH - 1) begin
					if (do_rem && (above || at)) begin
						ent_q[i] <= ent_q[(i < DEPTH - 1) ? i + 1 : i];
					end
				end
			end
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec) begin
			cnt_q <= cnt_d;
		end
	end

	assign cnt_wide = {{ECNT_W{1'b0}}, cnt_d};

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_status      <= stat_d;
			out_entry_count <= cnt_wide[ECNT_W-1:0];
			out_read_value  <= rd_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/array_insert_remove_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// A request is captured, then executed into the result register; the
// controller handles one item at a time (capture cycle, then execute cycle
// that waits for a free result register) and takes no new item until then.
// Entries past an insert point or from a removed one on move one place at once.
// Reset (arst_n, async, active low) clears the count and the handshake state;
// entry contents are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module array_insert_remove_engine_top
	import aire_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	aire_req_if.sink  req,
	aire_rsp_if.source rsp
);

	aire_cmd_t cmd;

	// Controller.
	aire_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// Datapath.
	aire_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.in_action       (req.action),
		.in_position     (req.position),
		.in_new_value    (req.new_value),
		.out_status      (rsp.status),
		.out_entry_count (rsp.entry_count),
		.out_read_value  (rsp.read_value)
	);

endmodule

`default_nettype wire

>>> tb/aire_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aire_checker: result checker for the array insert/remove engine
// Watches both channels, keeps a shadow copy of the ordered list, works out
// the result of every accepted operation and compares each returned result
// with the oldest one still owed. Hands the mismatch count and the number of
// owed results to the testbench top.
// ----------------------------------------------------------------------------
module aire_checker
	import aire_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	aire_req_if  req,
	aire_rsp_if  rsp,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic [ECNT_W-1:0]       entry_count;
		logic signed [VAL_W-1:0] read_value;
	} outcome_t;

	// Shadow copy of the list and its fill level.
	logic signed [VAL_W-1:0] slots [DEPTH];
	int                      slot_count;

	// Results owed by the block, oldest first.
	outcome_t owed_results [$];
	int       mismatch_cnt;

	// Applies one operation to the shadow list and returns the result it gives.
	function automatic outcome_t list_op_outcome(input logic [ACT_W-1:0] act,
		input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] val);
		outcome_t res;
		int       p;
		int       i;
		res.status     = ST_DONE;
		res.read_value = '0;
		p              = int'(pos);
		case (act)
			ACT_INSERT: begin
				// The position check comes before the full check.
				if (p > slot_count) begin
					res.status = ST_RANGE;
				end else if (slot_count >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (i = slot_count; i > p; i--)
						slots[i] = slots[i - 1];
					slots[p] = val;
					slot_count++;
				end
			end
			ACT_REMOVE: begin
				if (p >= slot_count) begin
					res.status = ST_RANGE;
				end else begin
					for (i = p; i + 1 < slot_count; i++)
						slots[i] = slots[i + 1];
					slot_count--;
				end
			end
			ACT_READ: begin
				if (p >= slot_count)
					res.status = ST_RANGE;
				else
					res.read_value = slots[p];
			end
			default: begin
				// The spare action code leaves everything as it is.
			end
		endcase
		res.entry_count = ECNT_W'(slot_count);
		return res;
	endfunction

	// Prints one line per mismatch and counts it.
	task automatic report(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_cnt++;
		$display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// Check returned results first, then record what the new operation owes.
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			owed_results.delete();
			slot_count   = 0;
			mismatch_cnt = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (owed_results.size() == 0) begin
					report("result with nothing outstanding", 32'(rsp.status), 32'hffff_ffff);
				end else begin
					want = owed_results.pop_front();
					if (rsp.status !== want.status)
						report("status", 32'(rsp.status), 32'(want.status));
					if (rsp.entry_count !== want.entry_count)
						report("entry_count", 32'(rsp.entry_count), 32'(want.entry_count));
					if (rsp.read_value !== want.read_value)
						report("read_value", rsp.read_value, want.read_value);
				end
			end
			if (req.valid && req.ready)
				owed_results.push_back(list_op_outcome(req.action, req.position, req.new_value));
			errors  <= mismatch_cnt;
			pending <= owed_results.size();
		end
	end

endmodule

>>> tb/tb_array_insert_remove_engine_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_array_insert_remove_engine_top: testbench for the insert/remove engine
// Drives a directed run through the empty, partly filled and full list, then
// several hundred random operations that fill and drain the list in turn.
// Both channels idle at random, and the result side holds off once for a long
// stretch so the engine backs up. The checker beside the engine judges every
// result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_array_insert_remove_engine_top;
	import aire_pkg::*;

	localparam int DEPTH          = DEPTH_DEF;
	localparam int RANDOM_OPS     = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_AFTER     = 120;
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_CYCLES   = 10;

	// The action code that the engine ignores.
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	logic clk;
	logic arst_n;

	aire_req_if req_ch ();
	aire_rsp_if rsp_ch ();

	int  errors;
	int  pending;
	int  accepted_ops = 0;
	int  quiet_cycles = 0;
	int  level;
	bit  calm;

	array_insert_remove_engine_top #(
		.DEPTH(DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	aire_checker #(
		.DEPTH(DEPTH)
	) checker_i (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.errors (errors),
		.pending(pending)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Count accepted operations and stop the run if the channels go silent.
	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready)
			accepted_ops <= accepted_ops + 1;
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side: random stalls, none while calm, and one long hold-off.
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held      = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && accepted_ops >= HOLD_AFTER) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (calm) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= 15);
			end
		end
	end

	// Offers one operation, with a random gap before it, and waits for it to
	// be taken. The fill level is tracked only to aim the positions.
	task automatic send_op(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
		input logic signed [VAL_W-1:0] val);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(99) < 15)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.action    <= act;
		req_ch.position  <= pos;
		req_ch.new_value <= val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (act == ACT_INSERT && int'(pos) <= level && level < DEPTH)
			level++;
		else if (act == ACT_REMOVE && int'(pos) < level)
			level--;
	endtask

	// Picks a value, with the extremes turning up often.
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(7))
			0:       return VAL_MAX;
			1:       return VAL_MIN;
			2:       return $urandom_range(1) ? '0 : '1;
			default: return $urandom;
		endcase
	endfunction

	// Stimulus and verdict.
	initial begin
		bit                grow;
		int                roll;
		logic [ACT_W-1:0]  act;
		logic [POS_W-1:0]  pos;
		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action    <= ACT_INSERT;
		req_ch.position  <= '0;
		req_ch.new_value <= '0;
		level = 0;
		calm  = 1'b0;
		grow  = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Operations on the empty list, including an insert past the end.
		send_op(ACT_READ, 4'd0, '0);
		send_op(ACT_REMOVE, 4'd0, '0);
		send_op(ACT_INSERT, 4'd1, VAL_MAX);

		// Fill the list, inserting at the front, the end and the middle.
		for (int i = 0; i < DEPTH; i++) begin
			case (i % 3)
				0: pos = '0;
				1: pos = POS_W'(level);
				default: pos = POS_W'(level / 2);
			endcase
			case (i)
				0: send_op(ACT_INSERT, pos, VAL_MAX);
				1: send_op(ACT_INSERT, pos, VAL_MIN);
				2: send_op(ACT_INSERT, pos, '0);
				3: send_op(ACT_INSERT, pos, '1);
				default: send_op(ACT_INSERT, pos, $urandom);
			endcase
		end

		// The full list: a dropped insert, reads at both ends, removals at both
		// ends, the spare action code and a read just past the end.
		send_op(ACT_INSERT, 4'd5, 32'sh1234_5678);
		send_op(ACT_READ, 4'd15, '0);
		send_op(ACT_READ, 4'd0, '0);
		send_op(ACT_REMOVE, 4'd15, '0);
		send_op(ACT_REMOVE, 4'd0, '0);
		send_op(ACT_UNUSED, 4'd15, VAL_MIN);
		send_op(ACT_READ, POS_W'(level), '0);

		// Random part: phases that fill and drain the list, plus some noise.
		for (int n = 0; n < RANDOM_OPS; n++) begin
			calm = (n >= 180 && n < 250);
			if (grow && level == DEPTH && $urandom_range(3) == 0)
				grow = 1'b0;
			else if (!grow && level == 0 && $urandom_range(3) == 0)
				grow = 1'b1;
			roll = $urandom_range(99);
			if ($urandom_range(9) == 0) begin
				act = ACT_W'($urandom_range(3));
				pos = POS_W'($urandom_range(15));
			end else begin
				if (roll < 60)
					act = grow ? ACT_INSERT : ACT_REMOVE;
				else if (roll < 85)
					act = ACT_READ;
				else
					act = grow ? ACT_REMOVE : ACT_INSERT;
				if (act == ACT_INSERT)
					pos = POS_W'($urandom_range(level < DEPTH ? level : DEPTH - 1));
				else
					pos = (level == 0) ? '0 : POS_W'($urandom_range(level - 1));
			end
			send_op(act, pos, pick_value());
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;

		// Wait for every owed result, then let any stray results show up.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
